// File: src/cigar_affine_gap_scorer_core_assert.svh
// ----------------------------------------------------------------------------
// CIGAR scorer assertion macros
// Shared concurrent assertion forms, clocked by clock, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CIGAR_AFFINE_GAP_SCORER_CORE_ASSERT_SVH
`define CIGAR_AFFINE_GAP_SCORER_CORE_ASSERT_SVH

// same-cycle implication
`define CAGS_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cags assertion failed");

// next-cycle implication
`define CAGS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cags assertion failed");

`endif

// File: src/cags_pkg.sv
// ----------------------------------------------------------------------------
// CIGAR scorer package
// Widths, character codes, operation codes and shared types.
// ----------------------------------------------------------------------------
package cags_pkg;

   localparam int RUN_BITS   = 24;
   localparam int SCORE_BITS = 32;
   localparam int EXT_BITS   = RUN_BITS + 1;
   localparam int PROD_BITS  = RUN_BITS + 9;
   localparam int DELTA_BITS = RUN_BITS + 10;
   localparam int SUM_BITS   = ((SCORE_BITS > DELTA_BITS) ? SCORE_BITS : DELTA_BITS) + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = PTR_BITS + 1;

   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_EQ   = 8'h3D;
   localparam logic [7:0] CHAR_X    = 8'h58;
   localparam logic [7:0] CHAR_I    = 8'h49;
   localparam logic [7:0] CHAR_D    = 8'h44;

   localparam logic [6:0]       RESET_MATCH    = 7'd1;
   localparam logic signed [7:0] RESET_MISMATCH = -8'sd1;
   localparam logic [6:0]       RESET_OPEN     = 7'd5;
   localparam logic [6:0]       RESET_EXTEND   = 7'd2;

   typedef enum logic [1:0] {
      OP_MATCH    = 2'd0,
      OP_MISMATCH = 2'd1,
      OP_INSERT   = 2'd2,
      OP_DELETE   = 2'd3
   } op_kind_type;

   typedef enum logic [1:0] {
      REG_MATCH    = 2'd0,
      REG_MISMATCH = 2'd1,
      REG_OPEN     = 2'd2,
      REG_EXTEND   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [6:0]        match_reward;
      logic signed [7:0] mismatch_score;
      logic [6:0]        gap_open_cost;
      logic [6:0]        gap_extend_cost;
   } cfg_type;

   typedef struct packed {
      logic [RUN_BITS-1:0] run;
      op_kind_type         kind;
      logic                bad;
      logic                last;
      logic                beat;
   } op_entry_type;

   typedef struct packed {
      logic [RUN_BITS-1:0]          run_length;
      op_kind_type                  op_kind;
      logic signed [SCORE_BITS-1:0] running_score;
      logic signed [EXT_BITS-1:0]   query_extent;
      logic signed [EXT_BITS-1:0]   target_extent;
      logic                         bad_symbol;
      logic                         last_of_string;
   } result_type;

endpackage

// File: src/cags_front.sv
// ----------------------------------------------------------------------------
// CIGAR scorer front end
// Builds run lengths from digits, classifies operation symbols, tracks the
// error state of the current string and queues one entry per operation and
// one to close a string that ends without a beat.
// ----------------------------------------------------------------------------
module cags_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_symbol,
   input  logic                   req_end_of_string,
   input  logic                   push,
   input  logic                   full,
   output logic                   link_push,
   output cags_pkg::op_entry_type link_entry
);

   logic [cags_pkg::RUN_BITS-1:0] run_ff, run_in;
   logic                          err_ff, err_in;
   logic                          accept;
   logic                          is_digit;
   logic                          bad;
   cags_pkg::op_kind_type         kind;
   logic [cags_pkg::RUN_BITS+3:0] run_wide;
   logic [cags_pkg::RUN_BITS-1:0] run_sat;

   assign accept = push && !full;

   always_comb begin
      is_digit = req_symbol inside {[cags_pkg::CHAR_ZERO:cags_pkg::CHAR_NINE]};
      bad      = 1'b0;
      case (req_symbol)
         cags_pkg::CHAR_EQ: kind = cags_pkg::OP_MATCH;
         cags_pkg::CHAR_X:  kind = cags_pkg::OP_MISMATCH;
         cags_pkg::CHAR_I:  kind = cags_pkg::OP_INSERT;
         cags_pkg::CHAR_D:  kind = cags_pkg::OP_DELETE;
         default: begin
            kind = cags_pkg::OP_MATCH;
            bad  = 1'b1;
         end
      endcase
   end

   // run * 10 + digit, saturating
   always_comb begin
      run_wide = {1'b0, run_ff, 3'b000} + {3'b000, run_ff, 1'b0}
               + (cags_pkg::RUN_BITS + 4)'(req_symbol - cags_pkg::CHAR_ZERO);
      run_sat  = (|run_wide[cags_pkg::RUN_BITS+3:cags_pkg::RUN_BITS])
               ? {cags_pkg::RUN_BITS{1'b1}} : run_wide[cags_pkg::RUN_BITS-1:0];
   end

   always_comb begin
      run_in          = run_ff;
      err_in          = err_ff;
      link_push       = 1'b0;
      link_entry.run  = run_ff;
      link_entry.kind = kind;
      link_entry.bad  = bad;
      link_entry.last = req_end_of_string;
      link_entry.beat = !err_ff && !is_digit;
      if (accept) begin
         if (err_ff) begin
            // drop the rest of a failed string
         end else if (is_digit) begin
            run_in = run_sat;
         end else begin
            link_push = 1'b1;
            if (bad) begin
               err_in = 1'b1;
            end else begin
               run_in = '0;
            end
         end
         if (req_end_of_string) begin
            link_push = 1'b1;
            run_in    = '0;
            err_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         err_ff <= err_in;
      end
   end

endmodule

// File: src/cags_link_queue.sv
// ----------------------------------------------------------------------------
// CIGAR scorer link queue
// Short queue of classified operations between front end and back end.
// ----------------------------------------------------------------------------
module cags_link_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   link_push,
   input  cags_pkg::op_entry_type link_entry,
   output logic                   full,
   input  logic                   link_pop,
   output logic                   link_empty,
   output cags_pkg::op_entry_type link_head
);

   cags_pkg::op_entry_type        mem_ff [cags_pkg::QUEUE_DEPTH];
   logic [cags_pkg::PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cags_pkg::PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cags_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign full       = (count_ff == cags_pkg::CNT_BITS'(cags_pkg::QUEUE_DEPTH));
   assign link_empty = (count_ff == '0);
   assign do_push    = link_push && !full;
   assign do_pop     = link_pop && !link_empty;
   assign link_head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + cags_pkg::PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + cags_pkg::PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + {{(cags_pkg::CNT_BITS-1){1'b0}}, do_push}
                           - {{(cags_pkg::CNT_BITS-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= link_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/cags_back.sv
// ----------------------------------------------------------------------------
// CIGAR scorer back end
// Forms the score change of each operation with one multiplier, then adds it
// to the saturating score, advances the extents and queues the result beat.
// ----------------------------------------------------------------------------
module cags_back (
   input  logic                   clock,
   input  logic                   reset,
   input  cags_pkg::cfg_type      cfg,
   input  logic                   link_empty,
   input  cags_pkg::op_entry_type link_head,
   output logic                   link_pop,
   output cags_pkg::result_type   rsp,
   output logic                   empty,
   input  logic                   pop
);

   // stage one: score change
   cags_pkg::op_entry_type               s1_op_ff, s1_op_in;
   logic signed [cags_pkg::DELTA_BITS-1:0] s1_delta_ff, s1_delta_in;
   logic                                 s1_valid_ff, s1_valid_in;
   logic                                 s1_ready;
   logic signed [7:0]                    coef;
   logic signed [cags_pkg::PROD_BITS-1:0] prod;
   logic signed [cags_pkg::DELTA_BITS-1:0] prod_ext;
   logic signed [cags_pkg::DELTA_BITS-1:0] open_ext;

   // accumulated string state
   logic signed [cags_pkg::SCORE_BITS-1:0] score_ff, score_in;
   logic signed [cags_pkg::EXT_BITS-1:0]   qpos_ff, qpos_in;
   logic signed [cags_pkg::EXT_BITS-1:0]   tpos_ff, tpos_in;
   logic signed [cags_pkg::SUM_BITS-1:0]   sum;
   logic [cags_pkg::SUM_BITS-cags_pkg::SCORE_BITS:0] sum_top;
   logic signed [cags_pkg::SCORE_BITS-1:0] score_sat;
   logic signed [cags_pkg::EXT_BITS-1:0]   qpos_adv, tpos_adv;
   logic                                 adv_q, adv_t;
   cags_pkg::result_type                 res;

   // result queue
   cags_pkg::result_type          out_mem_ff [cags_pkg::QUEUE_DEPTH];
   logic [cags_pkg::PTR_BITS-1:0] out_wr_ff, out_wr_in;
   logic [cags_pkg::PTR_BITS-1:0] out_rd_ff, out_rd_in;
   logic [cags_pkg::CNT_BITS-1:0] out_cnt_ff, out_cnt_in;
   logic                          out_full;
   logic                          retire;
   logic                          wr_beat;
   logic                          do_pop;

   function automatic logic signed [cags_pkg::EXT_BITS-1:0] advance(
      input logic signed [cags_pkg::EXT_BITS-1:0] pos,
      input logic [cags_pkg::RUN_BITS-1:0]        run
   );
      logic signed [cags_pkg::EXT_BITS:0] nxt;
      nxt = $signed({pos[cags_pkg::EXT_BITS-1], pos}) + $signed({2'b00, run});
      if (!nxt[cags_pkg::EXT_BITS] && nxt[cags_pkg::RUN_BITS]) begin
         return {1'b0, {cags_pkg::RUN_BITS{1'b1}}};
      end
      return nxt[cags_pkg::EXT_BITS-1:0];
   endfunction

   assign out_full = (out_cnt_ff == cags_pkg::CNT_BITS'(cags_pkg::QUEUE_DEPTH));
   assign empty    = (out_cnt_ff == '0);
   assign retire   = s1_valid_ff && !out_full;
   assign wr_beat  = retire && s1_op_ff.beat;
   assign s1_ready = !s1_valid_ff || !out_full;
   assign link_pop = !link_empty && s1_ready;
   assign do_pop   = pop && !empty;
   assign rsp      = out_mem_ff[out_rd_ff];

   always_comb begin
      case (link_head.kind)
         cags_pkg::OP_MATCH:    coef = $signed({1'b0, cfg.match_reward});
         cags_pkg::OP_MISMATCH: coef = cfg.mismatch_score;
         default:               coef = $signed({1'b0, cfg.gap_extend_cost});
      endcase
      prod     = cags_pkg::PROD_BITS'(coef)
               * cags_pkg::PROD_BITS'($signed({1'b0, link_head.run}));
      prod_ext = cags_pkg::DELTA_BITS'(prod);
      open_ext = cags_pkg::DELTA_BITS'($signed({1'b0, cfg.gap_open_cost}));
      if (link_head.kind == cags_pkg::OP_INSERT || link_head.kind == cags_pkg::OP_DELETE) begin
         s1_delta_in = -(prod_ext + open_ext);
      end else begin
         s1_delta_in = prod_ext;
      end
      s1_op_in    = link_pop ? link_head : s1_op_ff;
      if (!link_pop) begin
         s1_delta_in = s1_delta_ff;
      end
      s1_valid_in = link_pop ? 1'b1 : (retire ? 1'b0 : s1_valid_ff);
   end

   // add and saturate
   always_comb begin
      sum       = cags_pkg::SUM_BITS'(score_ff) + cags_pkg::SUM_BITS'(s1_delta_ff);
      sum_top   = sum[cags_pkg::SUM_BITS-1:cags_pkg::SCORE_BITS-1];
      if (&sum_top || ~|sum_top) begin
         score_sat = sum[cags_pkg::SCORE_BITS-1:0];
      end else if (sum[cags_pkg::SUM_BITS-1]) begin
         score_sat = {1'b1, {(cags_pkg::SCORE_BITS-1){1'b0}}};
      end else begin
         score_sat = {1'b0, {(cags_pkg::SCORE_BITS-1){1'b1}}};
      end
      qpos_adv = advance(qpos_ff, s1_op_ff.run);
      tpos_adv = advance(tpos_ff, s1_op_ff.run);
      adv_q    = (s1_op_ff.kind != cags_pkg::OP_DELETE);
      adv_t    = (s1_op_ff.kind != cags_pkg::OP_INSERT);

      res.run_length     = s1_op_ff.run;
      res.op_kind        = s1_op_ff.kind;
      res.bad_symbol     = s1_op_ff.bad;
      res.last_of_string = s1_op_ff.last;
      if (s1_op_ff.bad) begin
         res.running_score = score_ff;
         res.query_extent  = qpos_ff;
         res.target_extent = tpos_ff;
      end else begin
         res.running_score = score_sat;
         res.query_extent  = adv_q ? qpos_adv : qpos_ff;
         res.target_extent = adv_t ? tpos_adv : tpos_ff;
      end

      score_in = score_ff;
      qpos_in  = qpos_ff;
      tpos_in  = tpos_ff;
      if (retire) begin
         if (s1_op_ff.last) begin
            score_in = '0;
            qpos_in  = '1;
            tpos_in  = '1;
         end else begin
            score_in = res.running_score;
            qpos_in  = res.query_extent;
            tpos_in  = res.target_extent;
         end
      end
   end

   always_comb begin
      out_wr_in  = wr_beat ? out_wr_ff + cags_pkg::PTR_BITS'(1) : out_wr_ff;
      out_rd_in  = do_pop  ? out_rd_ff + cags_pkg::PTR_BITS'(1) : out_rd_ff;
      out_cnt_in = out_cnt_ff + {{(cags_pkg::CNT_BITS-1){1'b0}}, wr_beat}
                              - {{(cags_pkg::CNT_BITS-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_delta_ff <= s1_delta_in;
      if (wr_beat) begin
         out_mem_ff[out_wr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         score_ff    <= '0;
         qpos_ff     <= '1;
         tpos_ff     <= '1;
         out_wr_ff   <= '0;
         out_rd_ff   <= '0;
         out_cnt_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         score_ff    <= score_in;
         qpos_ff     <= qpos_in;
         tpos_ff     <= tpos_in;
         out_wr_ff   <= out_wr_in;
         out_rd_ff   <= out_rd_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

endmodule

// File: src/cigar_affine_gap_scorer_core.sv
// A taken operation passes the link queue, stage one and the result queue in turn.
// Throughput: one byte per cycle while full is low; the back end's score add and
// saturate loop closes on its own register, and the multiplier sits in the stage before it.
// Digits, bytes of a failed string and a digit marking the end give no beat.
// Reset: clears the run, score, error flag and both queues, sets both extents to
// -1, and loads the scoring registers with 1, -1, 5 and 2.
// ----------------------------------------------------------------------------
// CIGAR affine-gap scorer core
// Top level: scoring registers on the APB port, front end, link queue and
// back end.
// ----------------------------------------------------------------------------
module cigar_affine_gap_scorer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [7:0]                            req_symbol,
   input  logic                                  req_end_of_string,
   input  logic                                  push,
   output logic                                  full,
   output logic [cags_pkg::RUN_BITS-1:0]         rsp_run_length,
   output logic [1:0]                            rsp_op_kind,
   output logic signed [cags_pkg::SCORE_BITS-1:0] rsp_running_score,
   output logic signed [cags_pkg::EXT_BITS-1:0]  rsp_query_extent,
   output logic signed [cags_pkg::EXT_BITS-1:0]  rsp_target_extent,
   output logic                                  rsp_bad_symbol,
   output logic                                  rsp_last_of_string,
   output logic                                  empty,
   input  logic                                  pop,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cags_pkg::ADDR_BITS-1:0]        paddr,
   input  logic [cags_pkg::DATA_BITS-1:0]        pwdata,
   output logic [cags_pkg::DATA_BITS-1:0]        prdata,
   output logic                                  pready
);

   cags_pkg::cfg_type       cfg_ff, cfg_in;
   cags_pkg::reg_index_type reg_idx;
   logic                    wr_en;
   logic                    link_push;
   logic                    link_pop;
   logic                    link_empty;
   cags_pkg::op_entry_type  link_entry;
   cags_pkg::op_entry_type  link_head;
   cags_pkg::result_type    rsp;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = cags_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            cags_pkg::REG_MATCH:    cfg_in.match_reward    = pwdata[6:0];
            cags_pkg::REG_MISMATCH: cfg_in.mismatch_score  = $signed(pwdata[7:0]);
            cags_pkg::REG_OPEN:     cfg_in.gap_open_cost   = pwdata[6:0];
            cags_pkg::REG_EXTEND:   cfg_in.gap_extend_cost = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         cags_pkg::REG_MATCH:    prdata = {25'd0, cfg_ff.match_reward};
         cags_pkg::REG_MISMATCH: prdata = {24'd0, cfg_ff.mismatch_score};
         cags_pkg::REG_OPEN:     prdata = {25'd0, cfg_ff.gap_open_cost};
         cags_pkg::REG_EXTEND:   prdata = {25'd0, cfg_ff.gap_extend_cost};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_reward    <= cags_pkg::RESET_MATCH;
         cfg_ff.mismatch_score  <= cags_pkg::RESET_MISMATCH;
         cfg_ff.gap_open_cost   <= cags_pkg::RESET_OPEN;
         cfg_ff.gap_extend_cost <= cags_pkg::RESET_EXTEND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cags_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_symbol        (req_symbol),
      .req_end_of_string (req_end_of_string),
      .push              (push),
      .full              (full),
      .link_push         (link_push),
      .link_entry        (link_entry)
   );

   cags_link_queue u_link_queue (
      .clock      (clock),
      .reset      (reset),
      .link_push  (link_push),
      .link_entry (link_entry),
      .full       (full),
      .link_pop   (link_pop),
      .link_empty (link_empty),
      .link_head  (link_head)
   );

   cags_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .link_empty (link_empty),
      .link_head  (link_head),
      .link_pop   (link_pop),
      .rsp        (rsp),
      .empty      (empty),
      .pop        (pop)
   );

   assign rsp_run_length     = rsp.run_length;
   assign rsp_op_kind        = rsp.op_kind;
   assign rsp_running_score  = rsp.running_score;
   assign rsp_query_extent   = rsp.query_extent;
   assign rsp_target_extent  = rsp.target_extent;
   assign rsp_bad_symbol     = rsp.bad_symbol;
   assign rsp_last_of_string = rsp.last_of_string;

endmodule

// File: src/cags_checker.sv
// ----------------------------------------------------------------------------
// CIGAR scorer port checker
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
`include "cigar_affine_gap_scorer_core_assert.svh"

module cags_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  full,
   input logic                                  empty,
   input logic                                  pop,
   input logic [cags_pkg::RUN_BITS-1:0]         rsp_run_length,
   input logic [1:0]                            rsp_op_kind,
   input logic signed [cags_pkg::SCORE_BITS-1:0] rsp_running_score,
   input logic signed [cags_pkg::EXT_BITS-1:0]  rsp_query_extent,
   input logic signed [cags_pkg::EXT_BITS-1:0]  rsp_target_extent,
   input logic                                  rsp_bad_symbol
);

   `CAGS_ASSERT_IMPLIES(a_bad_kind, !empty && rsp_bad_symbol, rsp_op_kind == cags_pkg::OP_MATCH)
   `CAGS_ASSERT_IMPLIES(a_extent_floor, !empty, rsp_query_extent >= -1 && rsp_target_extent >= -1)
   `CAGS_ASSERT_IMPLIES(a_reset_idle, $past(reset), empty && !full)
   `CAGS_ASSERT_NEXT(a_beat_hold, !empty && !pop, !empty && $stable(rsp_run_length) && $stable(rsp_running_score))

endmodule

bind cigar_affine_gap_scorer_core cags_checker u_cags_checker (.*);
